>>> src/tmi_pkg.sv
// Package with opcodes, function codes, status codes and the source character map.
`timescale 1ns / 1ps

package tmi_pkg;

	localparam logic [1:0] FN_LOAD    = 2'd0;
	localparam logic [1:0] FN_STEP    = 2'd1;
	localparam logic [1:0] FN_RESTART = 2'd2;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_HALT  = 3'd1;
	localparam logic [2:0] ST_STACK = 3'd2;
	localparam logic [2:0] ST_BADOP = 3'd3;
	localparam logic [2:0] ST_FULL  = 3'd4;

	localparam logic [7:0] OP_NOP    = 8'd0;
	localparam logic [7:0] OP_INC    = 8'd1;
	localparam logic [7:0] OP_DEC    = 8'd2;
	localparam logic [7:0] OP_RIGHT  = 8'd3;
	localparam logic [7:0] OP_LEFT   = 8'd4;
	localparam logic [7:0] OP_IN     = 8'd5;
	localparam logic [7:0] OP_OUT    = 8'd6;
	localparam logic [7:0] OP_OPEN   = 8'd7;
	localparam logic [7:0] OP_CLOSE  = 8'd8;
	localparam logic [7:0] OP_COPYD  = 8'd9;
	localparam logic [7:0] OP_COPYP  = 8'd10;
	localparam logic [7:0] OP_PASTED = 8'd11;
	localparam logic [7:0] OP_PASTEP = 8'd12;
	localparam logic [7:0] OP_TRAP   = 8'd13;
	localparam logic [7:0] OP_HALT   = 8'd24;

	typedef struct packed {
		logic       known;
		logic [7:0] op;
	} char_map_t;

	typedef struct packed {
		logic rd_en;
		logic prog_we;
		logic data_we;
		logic stk_we;
	} mem_ctl_t;

	function automatic char_map_t map_char(input logic [7:0] c);
		char_map_t m;
		m.known = 1'b1;
		case (c)
			"+": m.op = OP_INC;
			"-": m.op = OP_DEC;
			">": m.op = OP_RIGHT;
			"<": m.op = OP_LEFT;
			",": m.op = OP_IN;
			".": m.op = OP_OUT;
			"[": m.op = OP_OPEN;
			"]": m.op = OP_CLOSE;
			"C": m.op = OP_COPYD;
			"c": m.op = OP_COPYP;
			"P": m.op = OP_PASTED;
			"p": m.op = OP_PASTEP;
			"T": m.op = OP_TRAP;
			"H": m.op = OP_HALT;
			default: begin
				m.known = 1'b0;
				m.op    = OP_NOP;
			end
		endcase
		return m;
	endfunction

endpackage

>>> src/tape_machine_interpreter_top.sv
// Tape-language machine top level: execute core with program, data and loop-stack RAMs.
//
// Input channel: in_valid, in_stall, words of func and byte_in. A word with func 0
// loads one source character, func 1 executes one instruction, func 2 restarts
// the program counter, clears the trap flag and resumes a stopped machine.
// Result channel: res_valid, res_stall, one result word per input word carrying
// status, out_valid, out_byte, trap_flag, prog_counter and data_pointer.
// Each accepted input word is registered into the execute stage, and its result word
// into the result register when it executes. A new input word is accepted only after
// the previous one has executed: the instruction fetch and the data and stack reads
// are registered in the synchronous RAMs, and the execute stage writes back the
// registers that address the next reads. After reset the three RAMs are cleared
// in a pass over all MEM_DEPTH addresses, during which in_stall is held high.
// While the receiver stalls, the result register holds its word; one further
// input word may be accepted and waits in the execute stage until the result
// register frees.
`timescale 1ns / 1ps

module tape_machine_interpreter_top import tmi_pkg::*; #(
	parameter int MEM_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [7:0] byte_in,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] status,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       trap_flag,
	output logic [7:0] prog_counter,
	output logic [7:0] data_pointer
);

	localparam int AW = $clog2(MEM_DEPTH);

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] prog_raddr, prog_waddr, data_raddr, data_waddr;
	logic [AW-1:0] stk_raddr, stk_waddr, stk_wdata, stk_rdata;
	logic [7:0]    prog_wdata, prog_rdata, data_wdata, data_rdata;

	tmi_core #(.MEM_DEPTH(MEM_DEPTH)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.byte_in      (byte_in),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.trap_flag    (trap_flag),
		.prog_counter (prog_counter),
		.data_pointer (data_pointer),
		.mem_ctl      (mem_ctl),
		.prog_raddr   (prog_raddr),
		.prog_waddr   (prog_waddr),
		.prog_wdata   (prog_wdata),
		.prog_rdata   (prog_rdata),
		.data_raddr   (data_raddr),
		.data_waddr   (data_waddr),
		.data_wdata   (data_wdata),
		.data_rdata   (data_rdata),
		.stk_raddr    (stk_raddr),
		.stk_waddr    (stk_waddr),
		.stk_wdata    (stk_wdata),
		.stk_rdata    (stk_rdata)
	);

	tmi_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_prog_ram (
		.clk   (clk),
		.we    (mem_ctl.prog_we),
		.waddr (prog_waddr),
		.wdata (prog_wdata),
		.re    (mem_ctl.rd_en),
		.raddr (prog_raddr),
		.rdata (prog_rdata)
	);

	tmi_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (mem_ctl.data_we),
		.waddr (data_waddr),
		.wdata (data_wdata),
		.re    (mem_ctl.rd_en),
		.raddr (data_raddr),
		.rdata (data_rdata)
	);

	tmi_ram #(.WIDTH(AW), .DEPTH(MEM_DEPTH)) u_stk_ram (
		.clk   (clk),
		.we    (mem_ctl.stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (mem_ctl.rd_en),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

`ifndef ASSERT_OFF
	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input word accepted while the previous one is still executing");

	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_valid) |-> (status == ST_OK))
		else $error("output byte emitted with a nonzero status");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> (out_byte == 8'd0))
		else $error("output byte nonzero without an output instruction");

	a_mem_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.rd_en |-> !(mem_ctl.prog_we || mem_ctl.data_we || mem_ctl.stk_we))
		else $error("memory read issued in the same cycle as a write-back");
`endif

endmodule

>>> src/tmi_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
`timescale 1ns / 1ps

module tmi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/tmi_core.sv
// Machine registers, execute stage, memory clearing pass and result register.
`timescale 1ns / 1ps

module tmi_core import tmi_pkg::*; #(
	parameter int MEM_DEPTH = 256,
	localparam int AW = $clog2(MEM_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    func,
	input  logic [7:0]    byte_in,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [2:0]    status,
	output logic          out_valid,
	output logic [7:0]    out_byte,
	output logic          trap_flag,
	output logic [7:0]    prog_counter,
	output logic [7:0]    data_pointer,
	output mem_ctl_t      mem_ctl,
	output logic [AW-1:0] prog_raddr,
	output logic [AW-1:0] prog_waddr,
	output logic [7:0]    prog_wdata,
	input  logic [7:0]    prog_rdata,
	output logic [AW-1:0] data_raddr,
	output logic [AW-1:0] data_waddr,
	output logic [7:0]    data_wdata,
	input  logic [7:0]    data_rdata,
	output logic [AW-1:0] stk_raddr,
	output logic [AW-1:0] stk_waddr,
	output logic [AW-1:0] stk_wdata,
	input  logic [AW-1:0] stk_rdata
);

	localparam int EW = AW + 8;
	localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);

	typedef enum logic [1:0] {RS_RUN, RS_HALT, RS_STACK, RS_BADOP} run_t;

	logic [AW-1:0] pc_q, dp_q, sp_q, clr_cnt_q;
	logic [7:0]    clip_q;
	logic          trap_q, s2_valid_q, clr_q, res_valid_q;
	run_t          run_q;

	logic [1:0]    func_s2;
	logic [7:0]    byte_s2;
	logic [AW-1:0] pcw_s2;

	logic [2:0] status_q;
	logic       ov_q, trap_out_q;
	logic [7:0] ob_q, pc_out_q, dp_out_q;

	logic          accept, fire;
	logic [AW-1:0] pc_fetch, pc_inc, pc_nxt, stk_tgt;
	char_map_t     mc;

	logic [AW-1:0] pc_d, dp_d, sp_d;
	logic [7:0]    clip_d, ob_d;
	logic          trap_d, ov_d;
	run_t          run_d;
	logic [2:0]    st_d;
	logic          pw_en, dw_en, sw_en;
	logic [AW-1:0] pw_addr;
	logic [7:0]    pw_data, dw_data;
	logic [EW-1:0] pc_ext, dp_ext;

	assign in_stall = clr_q | s2_valid_q;
	assign accept   = in_valid & ~in_stall;
	assign fire     = s2_valid_q & (~res_valid_q | ~res_stall);
	assign pc_fetch = (pc_q == LAST) ? '0 : pc_q;
	assign pc_inc   = pcw_s2 + 1'b1;
	assign pc_nxt   = (pc_inc == LAST) ? '0 : pc_inc;
	assign stk_tgt  = (stk_rdata == LAST) ? '0 : stk_rdata;
	assign mc       = map_char(byte_s2);

	always_comb begin
		pc_d    = pc_q;
		dp_d    = dp_q;
		sp_d    = sp_q;
		clip_d  = clip_q;
		trap_d  = trap_q;
		run_d   = run_q;
		st_d    = ST_OK;
		ov_d    = 1'b0;
		ob_d    = 8'd0;
		pw_en   = 1'b0;
		pw_addr = pc_q;
		pw_data = mc.op;
		dw_en   = 1'b0;
		dw_data = data_rdata;
		sw_en   = 1'b0;
		case (func_s2)
			FN_LOAD: begin
				if (mc.known) begin
					if (pc_q == LAST) begin
						st_d = ST_FULL;
					end else begin
						pw_en = 1'b1;
						pc_d  = pc_q + 1'b1;
					end
				end
			end
			FN_STEP: begin
				if (run_q != RS_RUN) begin
					st_d = {1'b0, run_q};
				end else begin
					pc_d = pc_nxt;
					case (prog_rdata)
						OP_NOP: ;
						OP_INC: begin
							dw_en   = 1'b1;
							dw_data = data_rdata + 8'd1;
						end
						OP_DEC: begin
							dw_en   = 1'b1;
							dw_data = data_rdata - 8'd1;
						end
						OP_RIGHT: dp_d = (dp_q == LAST) ? '0 : dp_q + 1'b1;
						OP_LEFT:  dp_d = (dp_q == '0) ? LAST : dp_q - 1'b1;
						OP_IN: begin
							dw_en   = 1'b1;
							dw_data = byte_s2;
						end
						OP_OUT: begin
							ov_d = 1'b1;
							ob_d = data_rdata;
						end
						OP_OPEN: begin
							if (sp_q == LAST) begin
								run_d = RS_STACK;
								st_d  = ST_STACK;
								pc_d  = pcw_s2;
							end else begin
								sp_d  = sp_q + 1'b1;
								sw_en = 1'b1;
							end
						end
						OP_CLOSE: begin
							if (data_rdata == 8'd0) begin
								if (sp_q == '0) begin
									run_d = RS_STACK;
									st_d  = ST_STACK;
									pc_d  = pcw_s2;
								end else begin
									sp_d = sp_q - 1'b1;
								end
							end else begin
								pc_d = stk_tgt;
							end
						end
						OP_COPYD:  clip_d = data_rdata;
						OP_COPYP:  clip_d = prog_rdata;
						OP_PASTED: begin
							dw_en   = 1'b1;
							dw_data = clip_q;
						end
						OP_PASTEP: begin
							pw_en   = 1'b1;
							pw_addr = pcw_s2;
							pw_data = clip_q;
						end
						OP_TRAP: trap_d = 1'b1;
						OP_HALT: begin
							run_d = RS_HALT;
							st_d  = ST_HALT;
							pc_d  = pcw_s2;
						end
						default: begin
							run_d = RS_BADOP;
							st_d  = ST_BADOP;
							pc_d  = pcw_s2;
						end
					endcase
				end
			end
			FN_RESTART: begin
				pc_d   = '0;
				trap_d = 1'b0;
				run_d  = RS_RUN;
			end
			default: ;
		endcase
	end

	assign pc_ext = EW'(pc_d);
	assign dp_ext = EW'(dp_d);

	always_comb begin
		mem_ctl.rd_en   = accept;
		mem_ctl.prog_we = clr_q | (fire & pw_en);
		mem_ctl.data_we = clr_q | (fire & dw_en);
		mem_ctl.stk_we  = clr_q | (fire & sw_en);
	end

	assign prog_raddr = pc_fetch;
	assign data_raddr = dp_q;
	assign stk_raddr  = sp_q;
	assign prog_waddr = clr_q ? clr_cnt_q : pw_addr;
	assign prog_wdata = clr_q ? 8'd0 : pw_data;
	assign data_waddr = clr_q ? clr_cnt_q : dp_q;
	assign data_wdata = clr_q ? 8'd0 : dw_data;
	assign stk_waddr  = clr_q ? clr_cnt_q : sp_q + 1'b1;
	assign stk_wdata  = clr_q ? '0 : pc_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			dp_q        <= '0;
			sp_q        <= '0;
			clip_q      <= 8'd0;
			trap_q      <= 1'b0;
			run_q       <= RS_RUN;
			s2_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == LAST) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				s2_valid_q <= 1'b1;
			end else if (fire) begin
				s2_valid_q <= 1'b0;
			end
			if (fire) begin
				pc_q        <= pc_d;
				dp_q        <= dp_d;
				sp_q        <= sp_d;
				clip_q      <= clip_d;
				trap_q      <= trap_d;
				run_q       <= run_d;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s2 <= func;
			byte_s2 <= byte_in;
			pcw_s2  <= pc_fetch;
		end
		if (fire) begin
			status_q   <= st_d;
			ov_q       <= ov_d;
			ob_q       <= ob_d;
			trap_out_q <= trap_d;
			pc_out_q   <= pc_ext[7:0];
			dp_out_q   <= dp_ext[7:0];
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign out_valid    = ov_q;
	assign out_byte     = ob_q;
	assign trap_flag    = trap_out_q;
	assign prog_counter = pc_out_q;
	assign data_pointer = dp_out_q;

endmodule

>>> test/tb_tape_machine_interpreter_top.sv
// Self-checking testbench for the tape-language machine: directed programs, random programs and stack overflow.
`timescale 1ns / 1ps

module tb_tape_machine_interpreter_top;
	import tmi_pkg::*;

	localparam int MEM_DEPTH = 256;

	typedef enum bit [1:0] {MS_RUN, MS_HALT, MS_STACK, MS_BADOP} mach_state_e;

	typedef struct packed {
		logic [2:0] status;
		logic       out_valid;
		logic [7:0] out_byte;
		logic       trap_flag;
		logic [7:0] prog_counter;
		logic [7:0] data_pointer;
	} report_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] func = FN_LOAD;
	logic [7:0] byte_in = 8'd0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [2:0] status;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       trap_flag;
	logic [7:0] prog_counter;
	logic [7:0] data_pointer;

	bit [7:0]    prog_img [MEM_DEPTH];
	bit [7:0]    tape_img [MEM_DEPTH];
	bit [7:0]    loop_img [MEM_DEPTH];
	bit [7:0]    pc_img;
	bit [7:0]    dp_img;
	bit [8:0]    sp_img;
	bit [7:0]    clip_img;
	bit          trap_img;
	mach_state_e mach_state = MS_RUN;

	report_t awaited_reports[$];
	int      err_count = 0;
	bit      tx_idle_on = 1'b1;
	bit      rx_idle_on = 1'b1;
	int      hold_req = 0;
	int      stall_left = 0;

	tape_machine_interpreter_top #(
		.MEM_DEPTH(MEM_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.byte_in(byte_in),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.trap_flag(trap_flag),
		.prog_counter(prog_counter),
		.data_pointer(data_pointer)
	);

	always #5 clk = ~clk;

	function automatic report_t interpret_word(input logic [1:0] f, input logic [7:0] b);
		report_t  r;
		logic     known;
		logic     advance;
		bit [7:0] op;
		bit [7:0] pc;
		bit [7:0] dp;
		r = '0;
		case (f)
			FN_LOAD: begin
				known = 1'b1;
				case (b)
					"+": op = OP_INC;
					"-": op = OP_DEC;
					">": op = OP_RIGHT;
					"<": op = OP_LEFT;
					",": op = OP_IN;
					".": op = OP_OUT;
					"[": op = OP_OPEN;
					"]": op = OP_CLOSE;
					"C": op = OP_COPYD;
					"c": op = OP_COPYP;
					"P": op = OP_PASTED;
					"p": op = OP_PASTEP;
					"T": op = OP_TRAP;
					"H": op = OP_HALT;
					default: begin
						known = 1'b0;
						op = OP_NOP;
					end
				endcase
				if (known) begin
					if (pc_img >= MEM_DEPTH - 1) begin
						r.status = ST_FULL;
					end else begin
						prog_img[pc_img] = op;
						pc_img++;
					end
				end
			end
			FN_STEP: begin
				if (mach_state != MS_RUN) begin
					case (mach_state)
						MS_HALT:  r.status = ST_HALT;
						MS_STACK: r.status = ST_STACK;
						default:  r.status = ST_BADOP;
					endcase
				end else begin
					pc = 8'(int'(pc_img) % (MEM_DEPTH - 1));
					pc_img = pc;
					dp = dp_img;
					op = prog_img[pc];
					advance = 1'b1;
					case (op)
						OP_NOP: ;
						OP_INC: tape_img[dp]++;
						OP_DEC: tape_img[dp]--;
						OP_RIGHT: dp_img = dp + 8'd1;
						OP_LEFT: dp_img = dp - 8'd1;
						OP_IN: tape_img[dp] = b;
						OP_OUT: begin
							r.out_valid = 1'b1;
							r.out_byte = tape_img[dp];
						end
						OP_OPEN: begin
							advance = 1'b0;
							if (sp_img >= MEM_DEPTH - 1) begin
								mach_state = MS_STACK;
								r.status = ST_STACK;
							end else begin
								sp_img++;
								pc_img = 8'((int'(pc) + 1) % (MEM_DEPTH - 1));
								loop_img[sp_img] = pc_img;
							end
						end
						OP_CLOSE: begin
							if (tape_img[dp] == 8'd0) begin
								if (sp_img == 9'd0) begin
									advance = 1'b0;
									mach_state = MS_STACK;
									r.status = ST_STACK;
								end else begin
									sp_img--;
								end
							end else begin
								advance = 1'b0;
								pc_img = 8'(int'(loop_img[sp_img]) % (MEM_DEPTH - 1));
							end
						end
						OP_COPYD: clip_img = tape_img[dp];
						OP_COPYP: clip_img = prog_img[pc];
						OP_PASTED: tape_img[dp] = clip_img;
						OP_PASTEP: prog_img[pc] = clip_img;
						OP_TRAP: trap_img = 1'b1;
						OP_HALT: begin
							advance = 1'b0;
							mach_state = MS_HALT;
							r.status = ST_HALT;
						end
						default: begin
							advance = 1'b0;
							mach_state = MS_BADOP;
							r.status = ST_BADOP;
						end
					endcase
					if (advance)
						pc_img = 8'((int'(pc) + 1) % (MEM_DEPTH - 1));
				end
			end
			FN_RESTART: begin
				pc_img = 8'd0;
				trap_img = 1'b0;
				mach_state = MS_RUN;
			end
			default: ;
		endcase
		r.trap_flag = trap_img;
		r.prog_counter = pc_img;
		r.data_pointer = dp_img;
		return r;
	endfunction

	task automatic send_word(input logic [1:0] f, input logic [7:0] b);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		byte_in <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		awaited_reports.push_back(interpret_word(f, b));
	endtask

	task automatic load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(FN_LOAD, s[i]);
	endtask

	task automatic run_steps(input int n);
		for (int i = 0; i < n; i++)
			send_word(FN_STEP, 8'($urandom));
	endtask

	task automatic wait_reports_done();
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_basic_ops();
		send_word(FN_STEP, 8'h00);
		send_word(2'b11, 8'hFF);
		send_word(FN_LOAD, 8'h00);
		send_word(FN_LOAD, 8'hFF);
		load_text("<-.>,.,.");
		send_word(FN_RESTART, 8'hFF);
		run_steps(4);
		send_word(FN_STEP, 8'hFF);
		run_steps(1);
		send_word(FN_STEP, 8'h00);
		run_steps(1);
		wait_reports_done();
	endtask

	task automatic test_loops();
		send_word(FN_RESTART, 8'h00);
		load_text("++[-]");
		send_word(FN_RESTART, 8'h00);
		run_steps(7);
		load_text("]");
		run_steps(2);
		send_word(FN_RESTART, 8'h00);
		load_text("+]");
		send_word(FN_RESTART, 8'h00);
		run_steps(3);
		wait_reports_done();
	endtask

	task automatic test_clipboard_trap_halt();
		send_word(FN_RESTART, 8'h00);
		load_text("cPC.TpH");
		send_word(FN_RESTART, 8'h00);
		run_steps(8);
		send_word(FN_RESTART, 8'h00);
		wait_reports_done();
	endtask

	task automatic test_bad_opcode();
		send_word(FN_RESTART, 8'h00);
		load_text(",Cp");
		send_word(FN_RESTART, 8'h00);
		send_word(FN_STEP, 8'hC8);
		run_steps(2);
		send_word(FN_RESTART, 8'h00);
		run_steps(4);
		load_text("+");
		send_word(FN_RESTART, 8'h00);
		run_steps(3);
		wait_reports_done();
	endtask

	task automatic test_result_backpressure();
		hold_req = 48;
		run_steps(12);
		wait_reports_done();
	endtask

	task automatic test_random_programs(input int budget);
		string ops = "++--><,..[]-[]CcPpTH";
		int    sent;
		int    len;
		int    n;
		sent = 0;
		while (sent < budget) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			send_word(FN_RESTART, 8'($urandom));
			len = $urandom_range(2, 16);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(FN_LOAD, 8'($urandom));
				else
					send_word(FN_LOAD, ops[$urandom_range(0, ops.len() - 1)]);
			end
			if ($urandom_range(0, 7) != 0)
				send_word(FN_RESTART, 8'($urandom));
			n = $urandom_range(len, 3 * len);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_word(2'($urandom), 8'($urandom));
				else
					send_word(FN_STEP, 8'($urandom));
			end
			sent += 2 + len + n;
		end
		wait_reports_done();
	endtask

	task automatic test_stack_overflow();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_word(FN_RESTART, 8'h00);
		for (int i = 0; i < MEM_DEPTH; i++)
			send_word(FN_LOAD, "[");
		send_word(FN_RESTART, 8'h00);
		run_steps(MEM_DEPTH + 1);
		send_word(FN_RESTART, 8'h00);
		wait_reports_done();
	endtask

	always @(posedge clk or negedge arst_n) begin : report_check
		report_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (awaited_reports.size() == 0) begin
					$error("result word with no expectation: status %0d", status);
					err_count++;
				end else begin
					want = awaited_reports.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						err_count++;
					end
					if (out_valid !== want.out_valid) begin
						$error("out_valid: expected %0d, got %0d", want.out_valid, out_valid);
						err_count++;
					end
					if (out_byte !== want.out_byte) begin
						$error("out_byte: expected %0d, got %0d", want.out_byte, out_byte);
						err_count++;
					end
					if (trap_flag !== want.trap_flag) begin
						$error("trap_flag: expected %0d, got %0d", want.trap_flag, trap_flag);
						err_count++;
					end
					if (prog_counter !== want.prog_counter) begin
						$error("prog_counter: expected %0d, got %0d", want.prog_counter,
							prog_counter);
						err_count++;
					end
					if (data_pointer !== want.data_pointer) begin
						$error("data_pointer: expected %0d, got %0d", want.data_pointer,
							data_pointer);
						err_count++;
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rx_hold
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 6);
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_ops();
		test_loops();
		test_clipboard_trap_halt();
		test_bad_opcode();
		test_result_backpressure();
		test_random_programs(450);
		test_stack_overflow();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> tape_machine_interpreter_top.f
src/tmi_pkg.sv
src/tmi_ram.sv
src/tmi_core.sv
src/tape_machine_interpreter_top.sv
test/tb_tape_machine_interpreter_top.sv
